// File: rtl/core/log_context_registry_table_macros.svh
// Assertion macros for the log context registry table checker.
`ifndef LOG_CONTEXT_REGISTRY_TABLE_MACROS_SVH
`define LOG_CONTEXT_REGISTRY_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCRT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lcrt_pkg.sv
// Shared types and constants of the log context registry table.
`timescale 1ns / 1ps

package lcrt_pkg;

    localparam int TAG_W    = 32;
    localparam int LEVEL_W  = 3;
    localparam int SLOT_W   = 6;
    localparam int HANDLE_W = 8;
    localparam int OP_W     = 3;

    localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL_RST = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER   = 3'd0,
        OP_GET        = 3'd1,
        OP_SET_HANDLE = 3'd2,
        OP_SET_ALL    = 3'd3,
        OP_SET_IDS    = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef struct packed {
        logic rd_en;
        logic id_we;
        logic lvl_we;
    } t_store_ctl;

endpackage

// File: rtl/core/log_context_registry_table.sv
// Per op: get reads the entry on a hit and goes straight to the result on a miss; clear,
// set-by-handle and unused ops go straight to the result; register scans for the first free
// entry, set-by-ids for the first match, set-all over every entry. One item at a time: the
// next can be taken in the cycle after the result loads; a stalled result holds the next.
// Scans step one entry per cycle over the valid bits and the single-port entry memory.
// Synchronous active-low reset empties the table and sets default_level to 4.
`timescale 1ns / 1ps

module log_context_registry_table import lcrt_pkg::*; #(
    parameter int MAX_CONTEXTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [TAG_W-1:0]    i_app_tag,
    input  logic [TAG_W-1:0]    i_ctx_tag,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [LEVEL_W-1:0]  i_new_level,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ok,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [TAG_W-1:0]    o_app_out,
    output logic [TAG_W-1:0]    o_ctx_out,
    output logic [LEVEL_W-1:0]  o_level_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LEVEL_W-1:0]  i_cfg_default_level
);

    localparam int IW = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CONTEXTS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_REG   = 8'b0000_0100,
        S_ALL   = 8'b0000_1000,
        S_IDRD  = 8'b0001_0000,
        S_IDCMP = 8'b0010_0000,
        S_GETW  = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [MAX_CONTEXTS-1:0] r_active, n_active;
    logic [IW-1:0]           r_idx, n_idx;
    logic [LEVEL_W-1:0]      r_default_level;

    t_op                     r_op;
    logic [TAG_W-1:0]        r_app_tag;
    logic [TAG_W-1:0]        r_ctx_tag;
    logic [HANDLE_W-1:0]     r_handle;
    logic [LEVEL_W-1:0]      r_new_level;

    logic                    r_res_ok, n_res_ok;
    logic [SLOT_W-1:0]       r_res_slot, n_res_slot;
    logic [TAG_W-1:0]        r_res_app, n_res_app;
    logic [TAG_W-1:0]        r_res_ctx, n_res_ctx;
    logic [LEVEL_W-1:0]      r_res_level, n_res_level;

    logic                    r_out_valid, n_out_valid;
    logic                    r_ok;
    logic [SLOT_W-1:0]       r_slot;
    logic [TAG_W-1:0]        r_app_out;
    logic [TAG_W-1:0]        r_ctx_out;
    logic [LEVEL_W-1:0]      r_level_out;

    t_store_ctl              s_ctl;
    logic [IW-1:0]           s_addr;
    logic [LEVEL_W-1:0]      s_lvl_wdata;
    logic [2*TAG_W-1:0]      s_id_rdata;
    logic [LEVEL_W-1:0]      s_lvl_rdata;
    logic [IW-1:0]           s_hidx;
    logic                    s_hit;
    logic                    s_in_acc;
    logic                    s_load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign s_hidx      = r_handle[IW-1:0];
    assign s_hit       = (r_handle < HANDLE_W'(MAX_CONTEXTS)) && r_active[s_hidx];
    assign s_load_out  = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    lcrt_store #(
        .MAX_CONTEXTS (MAX_CONTEXTS),
        .IW           (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (s_ctl),
        .i_addr      (s_addr),
        .i_id_wdata  ({r_app_tag, r_ctx_tag}),
        .i_lvl_wdata (s_lvl_wdata),
        .o_id_rdata  (s_id_rdata),
        .o_lvl_rdata (s_lvl_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_idx       = r_idx;
        n_res_ok    = r_res_ok;
        n_res_slot  = r_res_slot;
        n_res_app   = r_res_app;
        n_res_ctx   = r_res_ctx;
        n_res_level = r_res_level;
        n_out_valid = r_out_valid;
        s_ctl       = '0;
        s_addr      = r_idx;
        s_lvl_wdata = r_new_level;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_res_ok    = 1'b0;
                n_res_slot  = '0;
                n_res_app   = '0;
                n_res_ctx   = '0;
                n_res_level = '0;
                n_idx       = '0;
                if (s_in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                case (r_op)
                    OP_REGISTER: n_state = S_REG;
                    OP_GET: begin
                        n_res_slot = r_handle[SLOT_W-1:0];
                        if (s_hit) begin
                            s_ctl.rd_en = 1'b1;
                            s_addr      = s_hidx;
                            n_state     = S_GETW;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                    OP_SET_HANDLE: begin
                        n_res_slot = r_handle[SLOT_W-1:0];
                        if (s_hit) begin
                            s_ctl.lvl_we = 1'b1;
                            s_addr       = s_hidx;
                            n_res_ok     = 1'b1;
                        end
                        n_state = S_HOLD;
                    end
                    OP_SET_ALL: n_state = S_ALL;
                    OP_SET_IDS: n_state = S_IDRD;
                    OP_CLEAR: begin
                        n_active = '0;
                        n_res_ok = 1'b1;
                        n_state  = S_HOLD;
                    end
                    default: n_state = S_HOLD;
                endcase
            end
            S_REG: begin
                if (!r_active[r_idx]) begin
                    s_ctl.id_we     = 1'b1;
                    s_ctl.lvl_we    = 1'b1;
                    s_lvl_wdata     = r_default_level;
                    n_active[r_idx] = 1'b1;
                    n_res_ok        = 1'b1;
                    n_res_slot      = SLOT_W'(r_idx);
                    n_state         = S_HOLD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_HOLD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ALL: begin
                if (r_active[r_idx]) begin
                    s_ctl.lvl_we = 1'b1;
                    n_res_ok     = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_HOLD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDRD: begin
                s_ctl.rd_en = 1'b1;
                n_state     = S_IDCMP;
            end
            S_IDCMP: begin
                if (r_active[r_idx] && (s_id_rdata == {r_app_tag, r_ctx_tag})) begin
                    s_ctl.lvl_we = 1'b1;
                    n_res_ok     = 1'b1;
                    n_res_slot   = SLOT_W'(r_idx);
                    n_state      = S_HOLD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_HOLD;
                end else begin
                    // prefetch the next entry while comparing this one
                    s_ctl.rd_en = 1'b1;
                    s_addr      = r_idx + 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end
            S_GETW: begin
                n_res_ok    = 1'b1;
                n_res_app   = s_id_rdata[2*TAG_W-1:TAG_W];
                n_res_ctx   = s_id_rdata[TAG_W-1:0];
                n_res_level = s_lvl_rdata;
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (s_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_active        <= '0;
            r_out_valid     <= 1'b0;
            r_default_level <= DEFAULT_LEVEL_RST;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_default_level <= i_cfg_default_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_res_ok    <= n_res_ok;
        r_res_slot  <= n_res_slot;
        r_res_app   <= n_res_app;
        r_res_ctx   <= n_res_ctx;
        r_res_level <= n_res_level;
        if (s_in_acc) begin
            r_op        <= t_op'(i_op);
            r_app_tag   <= i_app_tag;
            r_ctx_tag   <= i_ctx_tag;
            r_handle    <= i_handle;
            r_new_level <= i_new_level;
        end
        if (s_load_out) begin
            r_ok        <= r_res_ok;
            r_slot      <= r_res_slot;
            r_app_out   <= r_res_app;
            r_ctx_out   <= r_res_ctx;
            r_level_out <= r_res_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_slot      = r_slot;
    assign o_app_out   = r_app_out;
    assign o_ctx_out   = r_ctx_out;
    assign o_level_out = r_level_out;

endmodule

// File: rtl/core/lcrt_store.sv
// Entry storage: id memory and level memory, registered read.
`timescale 1ns / 1ps

module lcrt_store import lcrt_pkg::*; #(
    parameter int MAX_CONTEXTS = 16,
    parameter int IW           = 4
) (
    input  logic                 i_clk,
    input  t_store_ctl           i_ctl,
    input  logic [IW-1:0]        i_addr,
    input  logic [2*TAG_W-1:0]   i_id_wdata,
    input  logic [LEVEL_W-1:0]   i_lvl_wdata,
    output logic [2*TAG_W-1:0]   o_id_rdata,
    output logic [LEVEL_W-1:0]   o_lvl_rdata
);

    logic [2*TAG_W-1:0] mem_id  [MAX_CONTEXTS];
    logic [LEVEL_W-1:0] mem_lvl [MAX_CONTEXTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.id_we) begin
            mem_id[i_addr] <= i_id_wdata;
        end
        if (i_ctl.rd_en) begin
            o_id_rdata <= mem_id[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lvl_we) begin
            mem_lvl[i_addr] <= i_lvl_wdata;
        end
        if (i_ctl.rd_en) begin
            o_lvl_rdata <= mem_lvl[i_addr];
        end
    end

endmodule

// File: rtl/core/lcrt_checker.sv
// Port-level checker for the log context registry table, with its bind.
`timescale 1ns / 1ps
`include "log_context_registry_table_macros.svh"

module lcrt_checker import lcrt_pkg::*; #(
    parameter int MAX_CONTEXTS = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_ok,
    input logic [SLOT_W-1:0]   o_slot,
    input logic [TAG_W-1:0]    o_app_out,
    input logic [TAG_W-1:0]    o_ctx_out,
    input logic [LEVEL_W-1:0]  o_level_out
);

    `LCRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_ok) && $stable(o_slot) && $stable(o_app_out),
        "stalled result item changed")

    `LCRT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "second item taken while one is in progress")

    `LCRT_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_ok,
        o_app_out == '0 && o_ctx_out == '0 && o_level_out == '0,
        "failed item carries entry data")

    `LCRT_ASSERT_IMPLY(a_slot_range, i_clk, i_rst_n, o_out_valid && o_ok,
        (SLOT_W+1)'(o_slot) < (SLOT_W+1)'(MAX_CONTEXTS),
        "successful item names a slot out of range")

endmodule

bind log_context_registry_table lcrt_checker #(.MAX_CONTEXTS(MAX_CONTEXTS)) u_checker (.*);
